// ----- sv/ihl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the indexed handle list.
// No dependencies; imported by ihl_cell and indexed_handle_list_core.
package ihl_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam logic [2:0] CMD_CLEAR      = 3'd0;
  localparam logic [2:0] CMD_APPEND     = 3'd1;
  localparam logic [2:0] CMD_INSERT     = 3'd2;
  localparam logic [2:0] CMD_READ       = 3'd3;
  localparam logic [2:0] CMD_REM_POS    = 3'd4;
  localparam logic [2:0] CMD_REM_HANDLE = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // What every cell does this cycle; each cell resolves it with its own
  // at / at-or-above flags.
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_INSERT,
    ACT_REMOVE
  } cell_act_t;

  typedef struct packed {
    cell_act_t act;
    handle_t   key;
  } cell_ctl_t;

endpackage

// ----- sv/ihl_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the handle list: holds one entry, compares it with
// the search key and takes data from its left or right neighbor. Uses ihl_pkg.
module ihl_cell import ihl_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      at,
  input  logic      ge,
  input  handle_t   left,
  input  handle_t   right,
  output handle_t   entry,
  output logic      match
);

  handle_t entry_next;

  always_comb begin
    entry_next = entry;
    case (ctl.act)
      ACT_LOAD: begin
        if (at) entry_next = ctl.key;
      end
      ACT_INSERT: begin
        if (at) entry_next = ctl.key;
        else if (ge) entry_next = left;
      end
      ACT_REMOVE: begin
        if (ge) entry_next = right;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign match = (entry == ctl.key);

endmodule

// ----- sv/indexed_handle_list_core.sv -----
`timescale 1ns / 1ps
// Top level of the indexed handle list: a row of ihl_cell storage cells,
// command decode, entry count and the result register. Uses ihl_pkg.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one request: command,
//   position and item_handle. Output channel (out_valid / out_ready)
//   returns one result per request: status and handle_out.
//   Each request is handled in parallel: all cells shift, load and compare
//   at once, so the list is updated at the accept edge and the result
//   appears in the output register on the next cycle.
//   Throughput is one request per cycle; the only limit is the single
//   result register, which is loaded again in the cycle it is taken.
//   When the receiver stalls (out_ready low with a result held), in_ready
//   drops and the list holds until the result is taken.
//   Reset empties the list (entry count to zero) and drops the output
//   valid. Cell contents are not cleared; only entries below the count are
//   ever read.
//   Remove-handle finds the first matching entry with a lowest-set-bit
//   isolate over the per-cell match flags, a single CAPACITY-bit add.
module indexed_handle_list_core import ihl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [5:0]  position,
  input  logic [31:0] item_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] handle_out
);

  cnt_t      entry_count;
  cnt_t      entry_count_next;
  logic      acc;
  handle_t   key;
  logic      key_nz;
  logic      full;
  logic      pos_in;
  idx_t      pos_idx;
  idx_t      target;
  logic      use_match;
  cell_ctl_t ctl;
  cell_act_t act;
  logic [1:0] st;
  handle_t   hout;
  handle_t   sel_entry;
  handle_t   hit_entry;

  handle_t              entries [CAPACITY];
  logic [CAPACITY-1:0]  cell_match;
  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY-1:0]  first_hit;
  logic [CAPACITY-1:0]  tail_mask;
  logic [CAPACITY-1:0]  at_vec;
  logic [CAPACITY-1:0]  ge_vec;
  logic                 found;

  // Take a new request whenever the result register is free or draining.
  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  assign key     = HANDLE_BITS'(item_handle);
  assign key_nz  = (key != '0);
  assign full    = (entry_count == CNT_W'(CAPACITY));
  assign pos_in  = (32'(position) < 32'(entry_count));
  assign pos_idx = IDX_W'(position);
  assign sel_entry = entries[pos_idx];

  // First matching entry: isolate the lowest set match bit, and mark it and
  // every cell above it for the shift-down.
  assign first_hit = hit & (~hit + CAPACITY'(1));
  assign tail_mask = hit | (~hit + CAPACITY'(1));
  assign found     = |hit;

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_entry = hit_entry | (entries[i] & {HANDLE_BITS{first_hit[i]}});
    end
  end

  // Command decode: pick the row action, target cell, count and result.
  always_comb begin
    act              = ACT_HOLD;
    target           = pos_idx;
    use_match        = 1'b0;
    entry_count_next = entry_count;
    st               = ST_OK;
    hout             = '0;
    case (command)
      CMD_CLEAR: begin
        entry_count_next = '0;
      end
      CMD_APPEND, CMD_INSERT: begin
        if (key_nz) begin
          if (full) begin
            st = ST_FULL;
          end else begin
            if (command == CMD_INSERT && pos_in) begin
              act = ACT_INSERT;
            end else begin
              act    = ACT_LOAD;
              target = IDX_W'(entry_count);
            end
            entry_count_next = entry_count + CNT_W'(1);
          end
        end
      end
      CMD_READ: begin
        if (pos_in) hout = sel_entry;
        else st = ST_NOT_FOUND;
      end
      CMD_REM_POS: begin
        if (pos_in) begin
          hout             = sel_entry;
          act              = ACT_REMOVE;
          entry_count_next = entry_count - CNT_W'(1);
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      CMD_REM_HANDLE: begin
        if (found) begin
          hout             = hit_entry;
          act              = ACT_REMOVE;
          use_match        = 1'b1;
          entry_count_next = entry_count - CNT_W'(1);
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    // Hold the row unless a request is taken this cycle.
    if (!acc) act = ACT_HOLD;
  end

  assign ctl.act = act;
  assign ctl.key = key;

  // Row of cells: each takes its left neighbor on insert, its right
  // neighbor on remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    handle_t left_in;
    handle_t right_in;

    if (i == 0) begin : g_first
      assign left_in = key;
    end else begin : g_mid_l
      assign left_in = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = entries[i];
    end else begin : g_mid_r
      assign right_in = entries[i+1];
    end

    assign at_vec[i] = (IDX_W'(i) == target);
    assign ge_vec[i] = use_match ? tail_mask[i] : (IDX_W'(i) >= target);
    assign hit[i]    = cell_match[i] && key_nz && (CNT_W'(i) < entry_count);

    ihl_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .at    (at_vec[i]),
      .ge    (ge_vec[i]),
      .left  (left_in),
      .right (right_in),
      .entry (entries[i]),
      .match (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (acc) begin
      entry_count <= entry_count_next;
    end
  end

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status     <= st;
      handle_out <= 32'(hout);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    acc && command == CMD_CLEAR |=> entry_count == '0)
    else $error("clear did not empty the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    acc && (command == CMD_APPEND || command == CMD_INSERT) && key_nz && full
    |=> out_valid && status == ST_FULL && handle_out == '0 && $stable(entry_count))
    else $error("full list did not report full");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    acc && command == CMD_REM_HANDLE && found
    |=> entry_count == $past(entry_count) - CNT_W'(1) && status == ST_OK)
    else $error("remove-handle did not shrink the list");

endmodule
